// ----- sv/tces_pkg.sv -----
// ----------------------------------------------------------------------------
// tces_pkg
// Shared types, codes and tables for the tracker channel effect step unit.
// ----------------------------------------------------------------------------
package tces_pkg;

    localparam int PERIOD_W = 12;
    localparam int VOL_W    = 7;
    localparam int PAN_W    = 8;
    localparam int TICK_W   = 5;
    localparam int PHASE_W  = 5;
    localparam int OFFS_W   = 16;
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 1;
    localparam int BIT_IDX_W = 3;

    localparam logic [PERIOD_W-1:0] PERIOD_MAX   = '1;
    localparam logic [VOL_W-1:0]    VOL_MAX      = 7'd64;
    localparam logic [PERIOD_W-1:0] MIN_PER_RST  = 12'd133;
    localparam logic [PERIOD_W-1:0] MAX_PER_RST  = 12'd856;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD = 1'b1;

    localparam logic [3:0] EFF_PORTA_UP     = 4'h1;
    localparam logic [3:0] EFF_PORTA_DOWN   = 4'h2;
    localparam logic [3:0] EFF_TONE_PORTA   = 4'h3;
    localparam logic [3:0] EFF_VIBRATO      = 4'h4;
    localparam logic [3:0] EFF_PORTA_VSLD   = 4'h5;
    localparam logic [3:0] EFF_VIB_VSLD     = 4'h6;
    localparam logic [3:0] EFF_SET_PAN      = 4'h8;
    localparam logic [3:0] EFF_SAMPLE_OFFS  = 4'h9;
    localparam logic [3:0] EFF_VOLUME_SLIDE = 4'hA;
    localparam logic [3:0] EFF_SET_VOL      = 4'hC;
    localparam logic [3:0] EFF_EXTENDED     = 4'hE;

    localparam logic [3:0] EXT_FINE_UP     = 4'h1;
    localparam logic [3:0] EXT_FINE_DOWN   = 4'h2;
    localparam logic [3:0] EXT_SET_PAN     = 4'h8;
    localparam logic [3:0] EXT_RETRIGGER   = 4'h9;
    localparam logic [3:0] EXT_FINE_VUP    = 4'hA;
    localparam logic [3:0] EXT_FINE_VDOWN  = 4'hB;
    localparam logic [3:0] EXT_NOTE_CUT    = 4'hC;
    localparam logic [3:0] EXT_NOTE_DELAY  = 4'hD;

    typedef struct packed {
        logic                 capture;
        logic                 step;
        logic [BIT_IDX_W-1:0] bit_idx;
        logic                 commit;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    function automatic logic [7:0] sine_lookup(input logic [PHASE_W-1:0] phase);
        logic [7:0] val;
        case (phase)
            5'd0:    val = 8'd0;
            5'd1:    val = 8'd24;
            5'd2:    val = 8'd49;
            5'd3:    val = 8'd74;
            5'd4:    val = 8'd97;
            5'd5:    val = 8'd120;
            5'd6:    val = 8'd141;
            5'd7:    val = 8'd161;
            5'd8:    val = 8'd180;
            5'd9:    val = 8'd197;
            5'd10:   val = 8'd212;
            5'd11:   val = 8'd224;
            5'd12:   val = 8'd235;
            5'd13:   val = 8'd244;
            5'd14:   val = 8'd250;
            5'd15:   val = 8'd253;
            5'd16:   val = 8'd255;
            5'd17:   val = 8'd253;
            5'd18:   val = 8'd250;
            5'd19:   val = 8'd244;
            5'd20:   val = 8'd235;
            5'd21:   val = 8'd224;
            5'd22:   val = 8'd212;
            5'd23:   val = 8'd197;
            5'd24:   val = 8'd180;
            5'd25:   val = 8'd161;
            5'd26:   val = 8'd141;
            5'd27:   val = 8'd120;
            5'd28:   val = 8'd97;
            5'd29:   val = 8'd74;
            5'd30:   val = 8'd49;
            5'd31:   val = 8'd24;
            default: val = 8'd0;
        endcase
        return val;
    endfunction

endpackage

// ----- sv/tces_ifs.sv -----
// ----------------------------------------------------------------------------
// tces_ifs
// Request and result channel interfaces of the tracker channel effect step unit.
// ----------------------------------------------------------------------------
interface tces_item_if;
    logic                           valid;
    logic                           ready;
    logic [tces_pkg::TICK_W-1:0]    tick;
    logic [3:0]                     effect;
    logic [7:0]                     effect_param;
    logic [tces_pkg::PERIOD_W-1:0]  note_period;
    logic [tces_pkg::PERIOD_W-1:0]  porta_target;
    logic                           load_note;

    modport source (
        output valid, tick, effect, effect_param, note_period, porta_target, load_note,
        input  ready
    );
    modport sink (
        input  valid, tick, effect, effect_param, note_period, porta_target, load_note,
        output ready
    );
endinterface

interface tces_result_if;
    logic                           valid;
    logic                           ready;
    logic [tces_pkg::PERIOD_W-1:0]  period;
    logic [tces_pkg::VOL_W-1:0]     volume;
    logic [tces_pkg::PAN_W-1:0]     pan;
    logic                           restart;
    logic [tces_pkg::OFFS_W-1:0]    restart_offset;

    modport source (
        output valid, period, volume, pan, restart, restart_offset,
        input  ready
    );
    modport sink (
        input  valid, period, volume, pan, restart, restart_offset,
        output ready
    );
endinterface

// ----- sv/tces_ctrl.sv -----
// ----------------------------------------------------------------------------
// tces_ctrl
// Sequencer: takes a request, runs the five remainder steps, then commits
// the tick into the channel state and the result register.
// ----------------------------------------------------------------------------
module tces_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tces_pkg::status_t  status,
    output tces_pkg::cmd_t     cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_COMMIT
    } state_t;

    state_t                               state_reg;
    logic                                 ready_reg;
    logic [tces_pkg::BIT_IDX_W-1:0]       idx_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && ready_reg) begin
                        state_reg <= ST_DIVIDE;
                        ready_reg <= 1'b0;
                        idx_reg   <= 3'(tces_pkg::TICK_W - 1);
                    end
                end
                ST_DIVIDE:
                begin
                    if (idx_reg == '0) begin
                        state_reg <= ST_COMMIT;
                    end
                    else begin
                        idx_reg <= idx_reg - 1'b1;
                    end
                end
                ST_COMMIT:
                begin
                    if (status.out_free) begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign in_ready    = ready_reg;
    assign cmd.capture = in_valid && ready_reg && (state_reg == ST_IDLE);
    assign cmd.step    = (state_reg == ST_DIVIDE);
    assign cmd.bit_idx = idx_reg;
    assign cmd.commit  = (state_reg == ST_COMMIT) && status.out_free;

endmodule

// ----- sv/tces_datapath.sv -----
// ----------------------------------------------------------------------------
// tces_datapath
// Request capture, channel state, configuration registers, remainder unit,
// effect evaluation and the result register.
// ----------------------------------------------------------------------------
module tces_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tces_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tces_pkg::CFG_W-1:0]          cfg_data,
    tces_item_if.sink                           items,
    tces_result_if.source                       results,
    input  tces_pkg::cmd_t                      cmd,
    output tces_pkg::status_t                   status
);

    localparam int PW = tces_pkg::PERIOD_W;
    localparam int VW = tces_pkg::VOL_W;

    logic [PW-1:0]                 min_period_reg;
    logic [PW-1:0]                 max_period_reg;

    logic [tces_pkg::TICK_W-1:0]   tick_reg;
    logic [3:0]                    effect_reg;
    logic [7:0]                    args_reg;
    logic [PW-1:0]                 note_reg;
    logic [PW-1:0]                 target_reg;
    logic                          load_reg;

    logic [PW-1:0]                 cur_period_reg;
    logic [VW-1:0]                 cur_volume_reg;
    logic [tces_pkg::PAN_W-1:0]    cur_pan_reg;
    logic [tces_pkg::PHASE_W-1:0]  vib_phase_reg;
    logic                          vib_negative_reg;

    logic [4:0]                    rem_reg;
    logic [4:0]                    rem_next;
    logic [4:0]                    rem_shift;
    logic [4:0]                    delta_reg;
    logic [11:0]                   vib_product;

    logic                          out_valid_reg;
    logic [PW-1:0]                 out_period_reg;
    logic [VW-1:0]                 out_volume_reg;
    logic [tces_pkg::PAN_W-1:0]    out_pan_reg;
    logic                          out_restart_reg;
    logic [tces_pkg::OFFS_W-1:0]   out_offset_reg;

    logic [PW-1:0]                 period_next;
    logic [VW-1:0]                 volume_next;
    logic [tces_pkg::PAN_W-1:0]    pan_next;
    logic [tces_pkg::PHASE_W-1:0]  phase_next;
    logic                          negative_next;
    logic                          restart_next;
    logic [tces_pkg::OFFS_W-1:0]   offset_next;

    logic [PW-1:0]                 p0;
    logic [3:0]                    arg_x;
    logic [3:0]                    arg_y;
    logic                          tick_zero;
    logic [PW-1:0]                 vib_period;
    logic [PW:0]                   vib_sum;
    logic [5:0]                    phase_sum;
    logic [VW-1:0]                 slid_volume;
    logic [tces_pkg::PHASE_W-1:0]  vib_phase_upd;
    logic                          vib_negative_upd;

    function automatic logic [PW-1:0] slide_up(input logic [PW-1:0] p,
                                               input logic [PW-1:0] lo,
                                               input logic [7:0]    amt);
        logic [PW:0] floor_sum;
        floor_sum = {1'b0, lo} + (PW+1)'(amt);
        if (p <= lo) begin
            return p;
        end
        if ({1'b0, p} < floor_sum) begin
            return lo;
        end
        return p - PW'(amt);
    endfunction

    function automatic logic [PW-1:0] slide_down(input logic [PW-1:0] p,
                                                 input logic [PW-1:0] hi,
                                                 input logic [7:0]    amt);
        logic [PW:0] sum;
        sum = {1'b0, p} + (PW+1)'(amt);
        if (p >= hi) begin
            return p;
        end
        if (sum > {1'b0, hi}) begin
            return hi;
        end
        return sum[PW-1:0];
    endfunction

    function automatic logic [VW-1:0] vol_add(input logic [VW-1:0] v,
                                              input logic [3:0]    amt);
        logic [VW-1:0] sum;
        sum = v + VW'(amt);
        return (sum > tces_pkg::VOL_MAX) ? tces_pkg::VOL_MAX : sum;
    endfunction

    function automatic logic [VW-1:0] vol_sub(input logic [VW-1:0] v,
                                              input logic [3:0]    amt);
        return (v < VW'(amt)) ? '0 : v - VW'(amt);
    endfunction

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            min_period_reg <= tces_pkg::MIN_PER_RST;
            max_period_reg <= tces_pkg::MAX_PER_RST;
        end
        else if (cfg_we) begin
            if (cfg_index == tces_pkg::CFG_MIN_PERIOD) begin
                min_period_reg <= cfg_data;
            end
            if (cfg_index == tces_pkg::CFG_MAX_PERIOD) begin
                max_period_reg <= cfg_data;
            end
        end
    end

    // Request capture.
    always_ff @(posedge clk) begin
        if (cmd.capture) begin
            tick_reg   <= items.tick;
            effect_reg <= items.effect;
            args_reg   <= items.effect_param;
            note_reg   <= items.note_period;
            target_reg <= items.porta_target;
            load_reg   <= items.load_note;
        end
    end

    // Restoring remainder of tick by the low argument nibble, one bit a step.
    assign rem_shift   = {rem_reg[3:0], tick_reg[cmd.bit_idx]};
    assign rem_next    = (rem_shift >= {1'b0, arg_y}) ? rem_shift - {1'b0, arg_y} : rem_shift;
    assign vib_product = 12'(tces_pkg::sine_lookup(vib_phase_reg)) * 12'(arg_y);

    always_ff @(posedge clk) begin
        if (cmd.capture) begin
            rem_reg <= '0;
        end
        else if (cmd.step) begin
            rem_reg   <= rem_next;
            delta_reg <= vib_product[11:7];
        end
    end

    assign arg_x     = args_reg[7:4];
    assign arg_y     = args_reg[3:0];
    assign tick_zero = (tick_reg == '0);
    assign p0        = load_reg ? note_reg : cur_period_reg;
    assign vib_sum   = {1'b0, note_reg} + (PW+1)'(delta_reg);
    assign phase_sum = {1'b0, vib_phase_reg} + {2'b00, arg_y};

    always_comb begin
        if (vib_negative_reg) begin
            vib_period = (note_reg < PW'(delta_reg)) ? '0 : note_reg - PW'(delta_reg);
        end
        else begin
            vib_period = vib_sum[PW] ? tces_pkg::PERIOD_MAX : vib_sum[PW-1:0];
        end
        if (phase_sum[5]) begin
            vib_phase_upd    = '0;
            vib_negative_upd = ~vib_negative_reg;
        end
        else begin
            vib_phase_upd    = phase_sum[4:0];
            vib_negative_upd = vib_negative_reg;
        end
        if (arg_x == 4'h0) begin
            slid_volume = vol_sub(cur_volume_reg, arg_y);
        end
        else if (arg_y == 4'h0) begin
            slid_volume = vol_add(cur_volume_reg, arg_x);
        end
        else begin
            slid_volume = cur_volume_reg;
        end
    end

    always_comb begin
        period_next   = p0;
        volume_next   = cur_volume_reg;
        pan_next      = cur_pan_reg;
        phase_next    = vib_phase_reg;
        negative_next = vib_negative_reg;
        restart_next  = 1'b0;
        offset_next   = '0;
        case (effect_reg)
            tces_pkg::EFF_PORTA_UP:
            begin
                if (!tick_zero) begin
                    period_next = slide_up(p0, min_period_reg, args_reg);
                end
            end
            tces_pkg::EFF_PORTA_DOWN:
            begin
                if (!tick_zero) begin
                    period_next = slide_down(p0, max_period_reg, args_reg);
                end
            end
            tces_pkg::EFF_TONE_PORTA, tces_pkg::EFF_PORTA_VSLD:
            begin
                if (!tick_zero) begin
                    if (target_reg > p0) begin
                        period_next = slide_down(p0, target_reg, args_reg);
                    end
                    else begin
                        period_next = slide_up(p0, target_reg, args_reg);
                    end
                end
                if (effect_reg == tces_pkg::EFF_PORTA_VSLD) begin
                    volume_next = slid_volume;
                end
            end
            tces_pkg::EFF_VIBRATO, tces_pkg::EFF_VIB_VSLD:
            begin
                period_next   = vib_period;
                phase_next    = vib_phase_upd;
                negative_next = vib_negative_upd;
                if (effect_reg == tces_pkg::EFF_VIB_VSLD) begin
                    volume_next = slid_volume;
                end
            end
            tces_pkg::EFF_SET_PAN:
            begin
                pan_next = args_reg;
            end
            tces_pkg::EFF_SAMPLE_OFFS:
            begin
                if (tick_zero) begin
                    restart_next = 1'b1;
                    offset_next  = {args_reg, 8'h00};
                end
            end
            tces_pkg::EFF_VOLUME_SLIDE:
            begin
                volume_next = slid_volume;
            end
            tces_pkg::EFF_SET_VOL:
            begin
                volume_next = (args_reg > 8'(tces_pkg::VOL_MAX)) ? tces_pkg::VOL_MAX
                                                                  : args_reg[VW-1:0];
            end
            tces_pkg::EFF_EXTENDED:
            begin
                case (arg_x)
                    tces_pkg::EXT_FINE_UP:
                    begin
                        if (tick_zero) begin
                            period_next = slide_up(p0, min_period_reg, {4'h0, arg_y});
                        end
                    end
                    tces_pkg::EXT_FINE_DOWN:
                    begin
                        if (tick_zero) begin
                            period_next = slide_down(p0, max_period_reg, {4'h0, arg_y});
                        end
                    end
                    tces_pkg::EXT_SET_PAN:
                    begin
                        pan_next = {arg_y, 4'h0} - {4'h0, arg_y};
                    end
                    tces_pkg::EXT_RETRIGGER:
                    begin
                        if ((arg_y != 4'h0) && (rem_reg == '0)) begin
                            restart_next = 1'b1;
                        end
                    end
                    tces_pkg::EXT_FINE_VUP:
                    begin
                        if (tick_zero) begin
                            volume_next = vol_add(cur_volume_reg, arg_y);
                        end
                    end
                    tces_pkg::EXT_FINE_VDOWN:
                    begin
                        if (tick_zero) begin
                            volume_next = vol_sub(cur_volume_reg, arg_y);
                        end
                    end
                    tces_pkg::EXT_NOTE_CUT:
                    begin
                        if (tick_reg == {1'b0, arg_y}) begin
                            period_next  = '0;
                            restart_next = 1'b1;
                        end
                    end
                    tces_pkg::EXT_NOTE_DELAY:
                    begin
                        if (tick_reg < {1'b0, arg_y}) begin
                            period_next = '0;
                        end
                        else if (tick_reg == {1'b0, arg_y}) begin
                            period_next = note_reg;
                        end
                    end
                    default:
                    begin
                        period_next = p0;
                    end
                endcase
            end
            default:
            begin
                period_next = p0;
            end
        endcase
    end

    // Channel state.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cur_period_reg   <= '0;
            cur_volume_reg   <= '0;
            cur_pan_reg      <= '0;
            vib_phase_reg    <= '0;
            vib_negative_reg <= 1'b0;
        end
        else if (cmd.commit) begin
            cur_period_reg   <= period_next;
            cur_volume_reg   <= volume_next;
            cur_pan_reg      <= pan_next;
            vib_phase_reg    <= phase_next;
            vib_negative_reg <= negative_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.commit) begin
            out_period_reg  <= period_next;
            out_volume_reg  <= volume_next;
            out_pan_reg     <= pan_next;
            out_restart_reg <= restart_next;
            out_offset_reg  <= offset_next;
        end
    end

    assign status.out_free        = !out_valid_reg || results.ready;
    assign results.valid          = out_valid_reg;
    assign results.period         = out_period_reg;
    assign results.volume         = out_volume_reg;
    assign results.pan            = out_pan_reg;
    assign results.restart        = out_restart_reg;
    assign results.restart_offset = out_offset_reg;

endmodule

// ----- sv/tracker_channel_effect_step_unit.sv -----
// ----------------------------------------------------------------------------
// tracker_channel_effect_step_unit
// Per-tick effect engine of one tracker channel: slides, tone portamento,
// vibrato, volume and pan commands, sample restart and note cut or delay.
//
//   Channel   Direction  Handshake     Carries
//   items     sink       valid/ready   tick, effect, arguments, note, target
//   results   source     valid/ready   period, volume, pan, restart, offset
//   cfg       sink       write enable  min_period (0), max_period (1)
//
// A request passes the accept, the steps of the bit-serial remainder unit
// for the retrigger test, and the commit.
// The result register frees the request side, so a new request is taken
// while the previous result waits; a held result only delays the commit.
// Reset is asynchronous and active low and needs no clearing pass.
// ----------------------------------------------------------------------------
module tracker_channel_effect_step_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tces_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tces_pkg::CFG_W-1:0]        cfg_data,
    tces_item_if.sink                         items,
    tces_result_if.source                     results
);

    tces_pkg::cmd_t     cmd;
    tces_pkg::status_t  status;

    tces_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_ready (items.ready),
        .status   (status),
        .cmd      (cmd)
    );

    tces_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .items     (items),
        .results   (results),
        .cmd       (cmd),
        .status    (status)
    );

`ifndef SYNTH
    a_ready_drops: assert property (@(posedge clk) disable iff (!rst_n)
        items.valid && items.ready |=> !items.ready)
        else $error("request side stayed ready after an accept");

    a_volume_range: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> results.volume <= tces_pkg::VOL_MAX)
        else $error("volume result above full scale");

    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.restart |-> results.restart_offset == '0)
        else $error("restart offset set without restart");

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !cmd.step && !cmd.capture)
        else $error("commit overlaps capture or remainder step");
`endif

endmodule
